// File: rtl/deadline_aware_window_reduce_core_assert.svh
// Assertion macros shared by the window reduction RTL.
`ifndef DEADLINE_AWARE_WINDOW_REDUCE_CORE_ASSERT_SVH
`define DEADLINE_AWARE_WINDOW_REDUCE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define DAWR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("window reduce assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define DAWR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("window reduce assertion failed");

`endif

// File: rtl/dawr_pkg.sv
// Types, constants and table builders for the window reduction core.
package dawr_pkg;

    localparam int ACC_W  = 105;
    localparam int SH_W   = 64;
    localparam int STEP_W = 7;
    localparam int CFG_W  = 62;
    localparam int IDX_W  = 3;

    localparam int POW_TABLE_BITS_DEF = 8;

    localparam logic [IDX_W-1:0] REG_PRIORITY  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SEGMENT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_BASE_RTT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_BYTE_TIME = 3'd3;
    localparam logic [IDX_W-1:0] REG_FLOW_SIZE = 3'd4;
    localparam logic [IDX_W-1:0] REG_FLOW_START = 3'd5;

    localparam logic [15:0] PRIORITY_RST  = 16'd512;
    localparam logic [15:0] SEGMENT_RST   = 16'd1000;
    localparam logic [31:0] BASE_RTT_RST  = 32'd10000;
    localparam logic [15:0] BYTE_TIME_RST = 16'd80;

    localparam logic [15:0] D_MAX = 16'd32768;
    localparam logic [15:0] D_MIN = 16'd8192;
    localparam logic [16:0] ALPHA_ONE = 17'd65536;
    localparam logic [61:0] TIME_MAX = {62{1'b1}};
    // ceil(2^57 / 125): exact floor(x / 125) for x below 2^53 as (x * k) >> 57
    localparam logic [50:0] NS_DIV_RECIP = 51'd1152921504606847;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        logic              start;
        t_op               op;
        logic [STEP_W-1:0] steps;
    } t_unit_req;

    typedef struct packed {
        logic busy;
    } t_unit_stat;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FT_GO,
        ST_FT_WAIT,
        ST_DK_GO,
        ST_DK_WAIT,
        ST_PO_GO,
        ST_PO_WAIT,
        ST_LEFT,
        ST_BM_GO,
        ST_BM_WAIT,
        ST_NM_GO,
        ST_NM_WAIT,
        ST_DN_GO,
        ST_DN_WAIT,
        ST_CMP,
        ST_DV_GO,
        ST_DV_WAIT,
        ST_LOG,
        ST_Y_GO,
        ST_Y_WAIT,
        ST_WM_GO,
        ST_WM_WAIT,
        ST_FIN
    } t_state;

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = n;
        res = 64'd0;
        b   = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (b != 64'd0) begin
                if (v >= res + b) begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] log_entry(input int i, input int bits);
        logic [63:0] x;
        logic [15:0] r;
        x = (64'(1 << bits) + 64'(i)) << (30 - bits);
        r = 16'd0;
        for (int b = 15; b >= 0; b--) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
                x    = x >> 1;
                r[b] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [16:0] exp_entry(input int i, input int bits);
        logic [63:0] roots [0:12];
        logic [63:0] acc;
        roots[0] = 64'd1 << 29;
        for (int k = 1; k <= 12; k++) begin
            roots[k] = isqrt64(roots[k-1] << 30);
        end
        acc = 64'd1 << 30;
        for (int k = 0; k < bits; k++) begin
            if (((i >> k) & 1) != 0) begin
                acc = (acc * roots[bits-k]) >> 30;
            end
        end
        return 17'((acc + (64'd1 << 13)) >> 14);
    endfunction

endpackage

// File: rtl/dawr_unit.sv
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module dawr_unit
    import dawr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_unit_req        i_req,
    input  logic [ACC_W-1:0] i_a,
    input  logic [ACC_W-1:0] i_b,
    input  logic [SH_W-1:0]  i_y,
    output t_unit_stat       o_stat,
    output logic [ACC_W-1:0] o_acc,
    output logic [SH_W-1:0]  o_q
);

    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  r_opd;
    logic [SH_W-1:0]   r_sh;
    logic [SH_W-1:0]   r_q;
    logic [STEP_W-1:0] r_cnt;
    t_op               r_op;
    logic              r_busy;

    logic [ACC_W:0]   w_addend;
    logic [ACC_W:0]   w_res;
    logic             w_ge;
    logic [ACC_W-1:0] w_rem;

    always_comb begin
        w_addend = (r_op == OP_DIV) ? ~{1'b0, r_opd} : {1'b0, r_opd};
        w_res    = {1'b0, r_acc} + w_addend + {{ACC_W{1'b0}}, (r_op == OP_DIV)};
        w_ge     = !w_res[ACC_W];
        w_rem    = w_ge ? w_res[ACC_W-1:0] : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op <= i_req.op;
            r_sh <= i_y;
            r_q  <= '0;
            if (i_req.op == OP_MUL) begin
                r_acc <= '0;
                r_opd <= i_a;
            end else begin
                r_acc <= i_a;
                r_opd <= i_b;
            end
        end else if (r_busy) begin
            if (r_op == OP_MUL) begin
                if (r_sh[0]) begin
                    r_acc <= w_res[ACC_W-1:0];
                end
                r_opd <= r_opd << 1;
                r_sh  <= r_sh >> 1;
            end else begin
                r_acc <= {w_rem[ACC_W-2:0], r_sh[SH_W-1]};
                r_sh  <= r_sh << 1;
                r_q   <= {r_q[SH_W-2:0], w_ge};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_acc       = r_acc;
    assign o_q         = r_q;

endmodule

// File: rtl/deadline_aware_window_reduce_core.sv
// Top level of the deadline-aware congestion window reduction core.
// One transaction in gives one transaction out. Every step of the work runs
// through a single shift-add multiplier / restoring divider that resolves one
// bit per cycle, so the item time is set by operand widths: a transaction
// whose deadline has passed or whose window is zero runs only the last two
// multiplies (16 and 17 bits), a normal one runs multiplies of 16, 32, 34, 16
// and 17 bits and, unless ST_CMP skips it, a 15-bit divide, and the first
// transaction after reset adds two 16-bit multiplies and a 51-bit reciprocal
// multiply for the divide by 1000 to fix the deadline.
// o_ready is high only between transactions; an untaken result in the output
// register holds the next one in ST_FIN, so o_ready stays low until i_ready.
`include "deadline_aware_window_reduce_core_assert.svh"

module deadline_aware_window_reduce_core
    import dawr_pkg::*;
#(
    parameter int POW_TABLE_BITS = POW_TABLE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [61:0]      i_now_ns,
    input  logic [23:0]      i_packets_left,
    input  logic [31:0]      i_window_bytes,
    input  logic [16:0]      i_mark_fraction,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [31:0]      o_new_window_bytes,
    output logic [15:0]      o_urgency,
    output logic             o_deadline_passed
);

    localparam int TBL = 1 << POW_TABLE_BITS;

    logic [15:0] w_log_tab [TBL];
    logic [16:0] w_exp_tab [TBL];

    for (genvar g = 0; g < TBL; g++) begin : g_tab
        assign w_log_tab[g] = log_entry(g, POW_TABLE_BITS);
        assign w_exp_tab[g] = exp_entry(g, POW_TABLE_BITS);
    end

    t_state r_state, n_state;

    logic [15:0] r_pri;
    logic [15:0] r_seg;
    logic [31:0] r_rtt;
    logic [15:0] r_bt;
    logic [39:0] r_flow;
    logic [61:0] r_start;
    logic [61:0] r_deadline;
    logic        r_known;

    logic [61:0]      r_now;
    logic [23:0]      r_pk;
    logic [31:0]      r_cwnd;
    logic [16:0]      r_alpha;
    logic [ACC_W-1:0] r_tmp;
    logic [95:0]      r_den;
    logic [61:0]      r_tleft;
    logic             r_passed;
    logic [15:0]      r_d;
    logic [20:0]      r_lg;
    logic [16:0]      r_pw;

    logic        r_out_valid;
    logic [31:0] r_out_win;
    logic [15:0] r_out_d;
    logic        r_out_passed;

    t_unit_req        w_req;
    t_unit_stat       w_stat;
    logic [ACC_W-1:0] w_a;
    logic [ACC_W-1:0] w_b;
    logic [SH_W-1:0]  w_y;
    logic [ACC_W-1:0] w_acc;
    logic [SH_W-1:0]  w_q;

    logic        w_accept;
    logic        w_future;
    logic        w_load_out;
    logic [62:0] w_dl_sum;
    logic [4:0]  w_p;
    logic [32:0] w_norm;
    logic [POW_TABLE_BITS-1:0] w_lidx;
    logic [21:0] w_yv;
    logic [POW_TABLE_BITS-1:0] w_eidx;
    logic [16:0] w_pw;

    dawr_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_y     (w_y),
        .o_stat  (w_stat),
        .o_acc   (w_acc),
        .o_q     (w_q)
    );

    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_future   = (r_deadline > r_now);
    assign w_load_out = (r_state == ST_FIN) && (!r_out_valid || i_ready);
    assign w_dl_sum   = {1'b0, r_start} + {8'b0, w_acc[62:8]};

    always_comb begin
        w_p = 5'd0;
        for (int k = 1; k <= 16; k++) begin
            if (r_alpha[k]) begin
                w_p = 5'(k);
            end
        end
        w_norm = {r_alpha[15:0], 17'd0} >> w_p;
        w_lidx = w_norm[16 -: POW_TABLE_BITS];
        w_yv   = w_acc[35:14];
        w_eidx = w_yv[15 -: POW_TABLE_BITS];
        w_pw   = (w_yv[21:16] > 6'd16) ? 17'd0 : (w_exp_tab[w_eidx] >> w_yv[21:16]);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_valid) n_state = r_known ? ST_LEFT : ST_FT_GO;
            ST_FT_GO:   n_state = ST_FT_WAIT;
            ST_FT_WAIT: if (!w_stat.busy) n_state = ST_DK_GO;
            ST_DK_GO:   n_state = ST_DK_WAIT;
            ST_DK_WAIT: if (!w_stat.busy) n_state = ST_PO_GO;
            ST_PO_GO:   n_state = ST_PO_WAIT;
            ST_PO_WAIT: if (!w_stat.busy) n_state = ST_LEFT;
            ST_LEFT:    n_state = (w_future && r_cwnd != 32'd0) ? ST_BM_GO : ST_LOG;
            ST_BM_GO:   n_state = ST_BM_WAIT;
            ST_BM_WAIT: if (!w_stat.busy) n_state = ST_NM_GO;
            ST_NM_GO:   n_state = ST_NM_WAIT;
            ST_NM_WAIT: if (!w_stat.busy) n_state = ST_DN_GO;
            ST_DN_GO:   n_state = ST_DN_WAIT;
            ST_DN_WAIT: if (!w_stat.busy) n_state = ST_CMP;
            ST_CMP:     n_state = (r_tmp >= ACC_W'({r_den, 1'b0})) ? ST_LOG : ST_DV_GO;
            ST_DV_GO:   n_state = ST_DV_WAIT;
            ST_DV_WAIT: if (!w_stat.busy) n_state = ST_LOG;
            ST_LOG:     n_state = ST_Y_GO;
            ST_Y_GO:    n_state = ST_Y_WAIT;
            ST_Y_WAIT:  if (!w_stat.busy) n_state = ST_WM_GO;
            ST_WM_GO:   n_state = ST_WM_WAIT;
            ST_WM_WAIT: if (!w_stat.busy) n_state = ST_FIN;
            ST_FIN:     if (w_load_out) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_req = '{start: 1'b0, op: OP_MUL, steps: '0};
        w_a   = '0;
        w_b   = '0;
        w_y   = '0;
        case (r_state)
            ST_FT_GO: begin
                w_req = '{start: 1'b1, op: OP_MUL, steps: STEP_W'(16)};
                w_a   = ACC_W'(r_flow);
                w_y   = SH_W'(r_bt);
            end
            ST_DK_GO: begin
                w_req = '{start: 1'b1, op: OP_MUL, steps: STEP_W'(51)};
                w_a   = ACC_W'(r_tmp[55:3]);
                w_y   = SH_W'(NS_DIV_RECIP);
            end
            ST_PO_GO: begin
                w_req = '{start: 1'b1, op: OP_MUL, steps: STEP_W'(16)};
                w_a   = r_tmp;
                w_y   = SH_W'(r_pri);
            end
            ST_BM_GO: begin
                w_req = '{start: 1'b1, op: OP_MUL, steps: STEP_W'(16)};
                w_a   = ACC_W'(r_pk);
                w_y   = SH_W'(r_seg);
            end
            ST_NM_GO: begin
                w_req = '{start: 1'b1, op: OP_MUL, steps: STEP_W'(32)};
                w_a   = r_tmp;
                w_y   = SH_W'(r_rtt);
            end
            ST_DN_GO: begin
                w_req = '{start: 1'b1, op: OP_MUL, steps: STEP_W'(34)};
                w_a   = ACC_W'(r_tleft);
                w_y   = SH_W'({r_cwnd, 1'b0}) + SH_W'(r_cwnd);
            end
            ST_DV_GO: begin
                w_req = '{start: 1'b1, op: OP_DIV, steps: STEP_W'(15)};
                w_a   = r_tmp;
                w_b   = ACC_W'(r_den);
            end
            ST_Y_GO: begin
                w_req = '{start: 1'b1, op: OP_MUL, steps: STEP_W'(16)};
                w_a   = ACC_W'(r_lg);
                w_y   = SH_W'(r_d);
            end
            ST_WM_GO: begin
                w_req = '{start: 1'b1, op: OP_MUL, steps: STEP_W'(17)};
                w_a   = ACC_W'(r_cwnd);
                w_y   = SH_W'(r_pw);
            end
            default: begin
                w_req = '{start: 1'b0, op: OP_MUL, steps: '0};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_known     <= 1'b0;
            r_deadline  <= '0;
            r_out_valid <= 1'b0;
            r_pri       <= PRIORITY_RST;
            r_seg       <= SEGMENT_RST;
            r_rtt       <= BASE_RTT_RST;
            r_bt        <= BYTE_TIME_RST;
            r_flow      <= '0;
            r_start     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_PRIORITY:   r_pri   <= i_cfg_data[15:0];
                    REG_SEGMENT:    r_seg   <= i_cfg_data[15:0];
                    REG_BASE_RTT:   r_rtt   <= i_cfg_data[31:0];
                    REG_BYTE_TIME:  r_bt    <= i_cfg_data[15:0];
                    REG_FLOW_SIZE:  r_flow  <= i_cfg_data[39:0];
                    REG_FLOW_START: r_start <= i_cfg_data[61:0];
                    default: ;
                endcase
            end
            if (r_state == ST_PO_WAIT && !w_stat.busy) begin
                r_known    <= 1'b1;
                r_deadline <= w_dl_sum[62] ? TIME_MAX : w_dl_sum[61:0];
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now   <= i_now_ns;
            r_pk    <= i_packets_left;
            r_cwnd  <= i_window_bytes;
            r_alpha <= (i_mark_fraction > ALPHA_ONE) ? ALPHA_ONE : i_mark_fraction;
        end
        case (r_state)
            ST_FT_WAIT: r_tmp <= w_acc;
            ST_DK_WAIT: r_tmp <= ACC_W'(r_rtt) + ACC_W'(w_acc[102:57]);
            ST_LEFT: begin
                r_tleft  <= w_future ? (r_deadline - r_now) : '0;
                r_passed <= !w_future;
                r_d      <= D_MAX;
            end
            ST_BM_WAIT: r_tmp <= w_acc;
            ST_NM_WAIT: r_tmp <= w_acc << 2;
            ST_DN_WAIT: r_den <= w_acc[95:0];
            ST_DV_WAIT: r_d <= (w_q[14:0] < D_MIN[14:0] && !w_q[15]) ? D_MIN : w_q[15:0];
            ST_LOG: begin
                r_lg <= {(5'd16 - w_p), 16'd0} - 21'(w_log_tab[w_lidx]);
            end
            ST_Y_WAIT: r_pw <= (r_alpha == 17'd0) ? 17'd0 : w_pw;
            default: ;
        endcase
        if (w_load_out) begin
            r_out_win    <= r_cwnd - w_acc[48:17];
            r_out_d      <= r_d;
            r_out_passed <= r_passed;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_new_window_bytes = r_out_win;
    assign o_urgency          = r_out_d;
    assign o_deadline_passed  = r_out_passed;

    `DAWR_ASSERT_NEXT(a_busy_after_accept, w_accept, !o_ready)
    `DAWR_ASSERT_IMPL(a_start_when_free, w_req.start, !w_stat.busy)
    `DAWR_ASSERT_IMPL(a_urgency_range, o_valid, o_urgency >= D_MIN && o_urgency <= D_MAX)
    `DAWR_ASSERT_IMPL(a_passed_full_urgency, o_valid && o_deadline_passed, o_urgency == D_MAX)

endmodule
